### design/pcd_pkg.sv
package pcd_pkg;

    localparam int CODE_BITS = 7;
    localparam int BYTE_W    = 8;
    localparam int COMP_W    = 8;
    localparam int IDX_W     = 7;
    localparam int CB_DEPTH  = 1 << IDX_W;
    localparam int BUF_W     = CODE_BITS - 1 + BYTE_W;
    localparam int HELD_W    = $clog2(BUF_W + 1);

    localparam logic [BUF_W-1:0] CODE_MASK = BUF_W'((1 << CODE_BITS) - 1);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_BYTE  = 1'b1
    } op_t;

    typedef struct packed {
        logic [COMP_W-1:0] comp2;
        logic [COMP_W-1:0] comp1;
        logic [COMP_W-1:0] comp0;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        entry_t           data;
    } cb_wr_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             last;
    } rd_req_t;

endpackage

### design/pcd_codebook.sv
module pcd_codebook (
    input  logic             aclk,
    input  pcd_pkg::cb_wr_t  cb_wr,
    input  pcd_pkg::rd_req_t rd_req,
    output pcd_pkg::entry_t  rd_data
);
    import pcd_pkg::*;

    entry_t mem [CB_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cb_wr.en) begin
            mem[cb_wr.idx] <= cb_wr.data;
        end
        if (rd_req.valid) begin
            rd_data_reg <= mem[rd_req.idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/pcd_unpacker.sv
module pcd_unpacker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic [pcd_pkg::BYTE_W-1:0]   s_code_byte,
    input  logic [pcd_pkg::IDX_W-1:0]    s_entry_index,
    input  logic [pcd_pkg::COMP_W-1:0]   s_entry_comp0,
    input  logic [pcd_pkg::COMP_W-1:0]   s_entry_comp1,
    input  logic [pcd_pkg::COMP_W-1:0]   s_entry_comp2,
    input  logic                         issue_ok,
    output pcd_pkg::rd_req_t             rd_req,
    output pcd_pkg::cb_wr_t              cb_wr
);
    import pcd_pkg::*;

    logic [BUF_W-1:0]  buf_reg, buf_next;
    logic [HELD_W-1:0] held_reg, held_next;

    logic              extracting;
    logic              fire;
    logic              last_code;
    logic              accept;
    logic [HELD_W-1:0] rem;
    logic [BUF_W-1:0]  low_mask;
    logic [BUF_W-1:0]  base_buf;
    logic [HELD_W-1:0] base_held;
    logic [BUF_W-1:0]  shifted;

    assign extracting = held_reg >= HELD_W'(CODE_BITS);
    assign rem        = held_reg - HELD_W'(CODE_BITS);
    assign last_code  = rem < HELD_W'(CODE_BITS);
    assign fire       = extracting && issue_ok;
    assign s_ready    = !extracting || (fire && last_code);
    assign accept     = s_valid && s_ready;
    assign low_mask   = ~({BUF_W{1'b1}} << rem);
    assign shifted    = buf_reg >> rem;

    always_comb begin
        base_buf  = fire ? (buf_reg & low_mask) : buf_reg;
        base_held = fire ? rem : held_reg;
        buf_next  = base_buf;
        held_next = base_held;
        if (accept && s_op == OP_BYTE) begin
            buf_next  = (base_buf << BYTE_W) | BUF_W'(s_code_byte);
            held_next = base_held + HELD_W'(BYTE_W);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg  <= '0;
            held_reg <= '0;
        end else begin
            buf_reg  <= buf_next;
            held_reg <= held_next;
        end
    end

    assign rd_req.valid = fire;
    assign rd_req.idx   = IDX_W'(shifted & CODE_MASK);
    assign rd_req.last  = last_code;

    assign cb_wr.en         = accept && s_op == OP_WRITE;
    assign cb_wr.idx        = s_entry_index;
    assign cb_wr.data.comp0 = s_entry_comp0;
    assign cb_wr.data.comp1 = s_entry_comp1;
    assign cb_wr.data.comp2 = s_entry_comp2;

endmodule

### design/pcd_out_stage.sv
module pcd_out_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pcd_pkg::rd_req_t            rd_req,
    input  pcd_pkg::entry_t             rd_data,
    output logic                        issue_ok,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pcd_pkg::COMP_W-1:0]  m_pixel_comp0,
    output logic [pcd_pkg::COMP_W-1:0]  m_pixel_comp1,
    output logic [pcd_pkg::COMP_W-1:0]  m_pixel_comp2,
    output logic [pcd_pkg::IDX_W-1:0]   m_code_index,
    output logic                        m_last_of_run
);
    import pcd_pkg::*;

    logic             p1_valid_reg;
    logic [IDX_W-1:0] p1_idx_reg;
    logic             p1_last_reg;
    logic             m_valid_reg;
    entry_t           m_entry_reg;
    logic [IDX_W-1:0] m_idx_reg;
    logic             m_last_reg;
    logic             p1_move;

    assign p1_move  = p1_valid_reg && (!m_valid_reg || m_ready);
    assign issue_ok = !p1_valid_reg || p1_move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (rd_req.valid) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_move) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_req.valid) begin
            p1_idx_reg  <= rd_req.idx;
            p1_last_reg <= rd_req.last;
        end
        if (p1_move) begin
            m_entry_reg <= rd_data;
            m_idx_reg   <= p1_idx_reg;
            m_last_reg  <= p1_last_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_comp0 = m_entry_reg.comp0;
    assign m_pixel_comp1 = m_entry_reg.comp1;
    assign m_pixel_comp2 = m_entry_reg.comp2;
    assign m_code_index  = m_idx_reg;
    assign m_last_of_run = m_last_reg;

endmodule

### design/packed_code_codebook_decoder.sv
// Channel   Handshake           Payload
// s_        s_valid / s_ready   s_op, s_code_byte, s_entry_index, s_entry_comp0..2
// m_        m_valid / m_ready   m_pixel_comp0..2, m_code_index, m_last_of_run
//
// One code is extracted per cycle while enough bits are held and the output is not stalled.
// Bytes and writes wait while codes remain; s_ready rises as the last one is extracted.
// After extraction, a result is registered by the memory read and then the output register.
// Reset clears the bit buffer and the valid flags; the codebook is not cleared.
// A stall on m_ready backs up through the read stage and holds extraction.
module packed_code_codebook_decoder (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic [pcd_pkg::BYTE_W-1:0]  s_code_byte,
    input  logic [pcd_pkg::IDX_W-1:0]   s_entry_index,
    input  logic [pcd_pkg::COMP_W-1:0]  s_entry_comp0,
    input  logic [pcd_pkg::COMP_W-1:0]  s_entry_comp1,
    input  logic [pcd_pkg::COMP_W-1:0]  s_entry_comp2,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pcd_pkg::COMP_W-1:0]  m_pixel_comp0,
    output logic [pcd_pkg::COMP_W-1:0]  m_pixel_comp1,
    output logic [pcd_pkg::COMP_W-1:0]  m_pixel_comp2,
    output logic [pcd_pkg::IDX_W-1:0]   m_code_index,
    output logic                        m_last_of_run
);
    import pcd_pkg::*;

    rd_req_t rd_req;
    cb_wr_t  cb_wr;
    entry_t  rd_data;
    logic    issue_ok;

    pcd_unpacker u_unpacker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_code_byte   (s_code_byte),
        .s_entry_index (s_entry_index),
        .s_entry_comp0 (s_entry_comp0),
        .s_entry_comp1 (s_entry_comp1),
        .s_entry_comp2 (s_entry_comp2),
        .issue_ok      (issue_ok),
        .rd_req        (rd_req),
        .cb_wr         (cb_wr)
    );

    pcd_codebook u_codebook (
        .aclk    (aclk),
        .cb_wr   (cb_wr),
        .rd_req  (rd_req),
        .rd_data (rd_data)
    );

    pcd_out_stage u_out_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rd_req        (rd_req),
        .rd_data       (rd_data),
        .issue_ok      (issue_ok),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_comp0 (m_pixel_comp0),
        .m_pixel_comp1 (m_pixel_comp1),
        .m_pixel_comp2 (m_pixel_comp2),
        .m_code_index  (m_code_index),
        .m_last_of_run (m_last_of_run)
    );

endmodule
